/* hdl/b64e_pkg.sv */
// Shared types and constants for the base64 stream encoder.
// Holds the job record passed from the front end to the back end
// and the sextet-to-character mapping. No dependencies.
package b64e_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
  localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'

  // One input byte's worth of output: up to four characters, the index of
  // the last one that is valid, and whether that one closes the message.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            eom;
  } job_t;

  // Maps a 6-bit group onto the standard alphabet.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h41 + w;
    end else if (v < 6'd52) begin
      return 8'h47 + w;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return PLUS_CHAR;
    end else begin
      return SLASH_CHAR;
    end
  endfunction

endpackage

/* hdl/b64e_front.sv */
// Front end of the base64 stream encoder: tracks the byte phase and the
// leftover bits, and turns each accepted byte into a job record.
// Depends on b64e_pkg.
module b64e_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         data_byte,
  input  logic               end_of_message,
  input  logic               accept,
  output b64e_pkg::job_t     job
);

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [3:0] carry;
  logic [3:0] carry_next;

  always_comb begin
    job.chars    = '0;
    job.last_idx = 2'd0;
    job.eom      = end_of_message;
    phase_next   = PH_0;
    carry_next   = 4'd0;
    unique case (phase)
      PH_1: begin
        job.chars[0] = b64e_pkg::sextet_char({carry[1:0], data_byte[7:4]});
        if (end_of_message) begin
          job.chars[1] = b64e_pkg::sextet_char({data_byte[3:0], 2'b00});
          job.chars[2] = b64e_pkg::PAD_CHAR;
          job.last_idx = 2'd2;
        end
        phase_next = PH_2;
        carry_next = data_byte[3:0];
      end
      PH_2: begin
        job.chars[0] = b64e_pkg::sextet_char({carry, data_byte[7:6]});
        job.chars[1] = b64e_pkg::sextet_char(data_byte[5:0]);
        job.last_idx = 2'd1;
      end
      default: begin
        // Phase 0, and the unused code, which behaves as phase 0.
        job.chars[0] = b64e_pkg::sextet_char(data_byte[7:2]);
        if (end_of_message) begin
          job.chars[1] = b64e_pkg::sextet_char({data_byte[1:0], 4'b0000});
          job.chars[2] = b64e_pkg::PAD_CHAR;
          job.chars[3] = b64e_pkg::PAD_CHAR;
          job.last_idx = 2'd3;
        end
        phase_next = PH_1;
        carry_next = {2'b00, data_byte[1:0]};
      end
    endcase
    // A finished message returns to the start of a new group.
    if (end_of_message) begin
      phase_next = PH_0;
      carry_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_0;
      carry <= 4'd0;
    end else if (accept) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

/* hdl/b64e_fifo.sv */
// Small job queue between the front and back ends of the encoder.
// Register array with read and write pointers. Depends on b64e_pkg.
module b64e_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  b64e_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output b64e_pkg::job_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64e_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/b64e_back.sv */
// Back end of the encoder: holds one job and sends its characters one per
// cycle on the output stream while out_ready is high. Depends on b64e_pkg.
module b64e_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  b64e_pkg::job_t job_in,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     ascii_char,
  output logic           last_of_run,
  output logic           end_of_output
);

  b64e_pkg::job_t cur;
  logic           busy;
  logic [1:0]     idx;
  logic           at_last;
  logic           fire;

  assign at_last       = (idx == cur.last_idx);
  assign fire          = busy && out_ready;
  assign job_ready     = !busy || (fire && at_last);
  assign out_valid     = busy;
  assign ascii_char    = cur.chars[idx];
  assign last_of_run   = at_last;
  assign end_of_output = at_last && cur.eom;

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cur <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (job_ready) begin
      busy <= job_valid;
      idx  <= 2'd0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

/* hdl/base64_stream_encoder.sv */
// Streaming base64 encoder, standard alphabet with '=' padding.
// With the back end idle, a byte's job is written into the queue and is then loaded
// into the back end before its first character leaves, and waits while the output stalls.
// Throughput: one character per cycle at the output while m_tready is high; a byte
// gives 1 or 2 characters (4 per 3 bytes) and a final byte up to 4.
// Input is taken every cycle while the job queue has room; the output port sets the pace.
// Reset (rst, synchronous) empties the queue and returns to the start of a 3-byte group.
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_message
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] ascii_char
  output logic       m_tlast,   // end_of_output
  output logic       m_tuser    // [0] last_of_run
);

  // The front end classifies each byte by its place in the 3-byte group and
  // builds a job of up to four characters. The queue lets the front keep
  // taking bytes while the back end is still sending earlier characters.
  b64e_pkg::job_t front_job;
  b64e_pkg::job_t queue_job;
  logic           in_xfer;
  logic           queue_valid;
  logic           back_ready;

  assign in_xfer = s_tvalid && s_tready;

  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (s_tdata),
    .end_of_message (s_tlast),
    .accept         (in_xfer),
    .job            (front_job)
  );

  b64e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_data  (front_job),
    .pop_valid  (queue_valid),
    .pop_ready  (back_ready),
    .pop_data   (queue_job)
  );

  // The back end sends one character per transfer and picks up the next job
  // in the same cycle that its last character leaves, so there is no gap.
  b64e_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (queue_valid),
    .job_ready     (back_ready),
    .job_in        (queue_job),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .ascii_char    (m_tdata),
    .last_of_run   (m_tuser),
    .end_of_output (m_tlast)
  );

endmodule
